### hdl/rmm_pkg.sv
// types and constants shared by the piecewise rate mass map
`default_nettype none
package rmm_pkg;
	localparam int POS_W   = 32;
	localparam int RATE_W  = 16;
	localparam int MASS_W  = 48;
	localparam int SUM_W   = 49;
	localparam int IDX_W   = 11;
	localparam int MODE_W  = 3;
	localparam int ST_W    = 3;
	localparam int DIV_STEPS = 49;
	localparam int DCNT_W  = 6;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INDEX  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_P2M    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_M2P    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SHIFT  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_UNSORTED = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [ST_W-1:0] ST_SAT      = 3'd4;

	localparam logic [1:0] RS_LO  = 2'd0;
	localparam logic [1:0] RS_MID = 2'd1;
	localparam logic [1:0] RS_CNT = 2'd2;

	typedef struct packed {
		logic            load;
		logic            clr_count;
		logic [1:0]      rsel;
		logic            init_b;
		logic            init_m;
		logic            cmp_b;
		logic            cmp_m;
		logic            mul;
		logic            mul_app;
		logic            app_wr;
		logic            p2m_fin;
		logic            set_m_mass;
		logic            set_m_sum;
		logic            idx_lo;
		logic            idx_cnt;
		logic            idx_zero;
		logic            st_we;
		logic [ST_W-1:0] st_code;
		logic            po_sat;
		logic            div_init;
		logic            div_step;
		logic            div_fin;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic n_zero;
		logic lo_lt_hi;
		logic m_zero;
		logic r_zero;
		logic unsorted;
		logic div_last;
	} sts_t;
endpackage
`default_nettype wire

### hdl/piecewise_rate_mass_map_top.sv
// piecewise rate mass map: top level joining controller and datapath
// done follows the accepting edge in every mode: clear, append, index, position to mass,
// mass to position and shift; the last two search by mass and use a 49-step divider
// a new item is taken in the cycle after done, not in the done cycle itself
// arst_n empties the map; done pulses one cycle, no stall
`default_nettype none
module piecewise_rate_mass_map_top #(
	parameter int MAX_INTERVALS = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [rmm_pkg::MODE_W-1:0]  mode,
	input  wire logic [rmm_pkg::POS_W-1:0]   position,
	input  wire logic [rmm_pkg::RATE_W-1:0]  rate,
	input  wire logic [rmm_pkg::MASS_W-1:0]  mass,
	output logic                            done,
	output logic [rmm_pkg::MASS_W-1:0]       mass_out,
	output logic [rmm_pkg::POS_W-1:0]        position_out,
	output logic [rmm_pkg::IDX_W-1:0]        interval_index,
	output logic [rmm_pkg::ST_W-1:0]         status
);
	import rmm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rmm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	rmm_dp #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.position       (position),
		.rate           (rate),
		.mass           (mass),
		.mass_out       (mass_out),
		.position_out   (position_out),
		.interval_index (interval_index),
		.status         (status)
	);
endmodule
`default_nettype wire

### hdl/rmm_dp.sv
// datapath: interval tables, search registers, multiplier and serial divider
`default_nettype none
module rmm_dp #(
	parameter int MAX_INTERVALS = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rmm_pkg::cmd_t             cmd,
	output rmm_pkg::sts_t                  sts,
	input  wire logic [rmm_pkg::POS_W-1:0]  position,
	input  wire logic [rmm_pkg::RATE_W-1:0] rate,
	input  wire logic [rmm_pkg::MASS_W-1:0] mass,
	output logic [rmm_pkg::MASS_W-1:0]      mass_out,
	output logic [rmm_pkg::POS_W-1:0]       position_out,
	output logic [rmm_pkg::IDX_W-1:0]       interval_index,
	output logic [rmm_pkg::ST_W-1:0]        status
);
	import rmm_pkg::*;

	localparam int CW  = $clog2(MAX_INTERVALS + 1);
	localparam int RAW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

	logic [POS_W-1:0]  bmem [0:MAX_INTERVALS];
	logic [MASS_W-1:0] cmem [0:MAX_INTERVALS];
	logic [RATE_W-1:0] rmem [0:MAX_INTERVALS-1];

	logic [POS_W-1:0]  pos_q;
	logic [RATE_W-1:0] rate_q;
	logic [MASS_W-1:0] mass_q;
	logic [SUM_W-1:0]  m_q;
	logic [CW-1:0]     count_q, lo_q, hi_q, idx_q;
	logic [POS_W-1:0]  rd_b_q;
	logic [MASS_W-1:0] rd_c_q;
	logic [RATE_W-1:0] rd_r_q;
	logic              z_q;
	logic [MASS_W-1:0] prod_q, mo_q;
	logic [POS_W-1:0]  po_q;
	logic [ST_W-1:0]   st_q;
	logic [RATE_W:0]   rem_q;
	logic [SUM_W-1:0]  dq_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [CW:0]       span;
	logic [CW-1:0]     mid, raddr, cnt_p1;
	logic [POS_W-1:0]  b_eff;
	logic [MASS_W-1:0] c_eff, cum_new;
	logic [RATE_W-1:0] r_mul;
	logic [RATE_W:0]   rem2;
	logic              ge;
	logic [SUM_W:0]    psum;
	logic [SUM_W-1:0]  msum;

	assign span    = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
	assign mid     = lo_q + CW'(span >> 1);
	assign cnt_p1  = count_q + 1'b1;
	assign b_eff   = z_q ? '0 : rd_b_q;
	assign c_eff   = z_q ? '0 : rd_c_q;
	assign r_mul   = cmd.mul_app ? rate_q : rd_r_q;
	assign cum_new = c_eff + prod_q;
	assign rem2    = {rem_q[RATE_W-1:0], dq_q[SUM_W-1]};
	assign ge      = rem2 >= {1'b0, rd_r_q};
	assign psum    = {{(SUM_W+1-POS_W){1'b0}}, b_eff} + {1'b0, dq_q};
	assign msum    = {1'b0, mo_q} + {1'b0, mass_q};

	always_comb begin
		case (cmd.rsel)
			RS_MID:  raddr = mid;
			RS_CNT:  raddr = count_q;
			default: raddr = lo_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.app_wr) begin
			bmem[cnt_p1] <= pos_q;
		end
		rd_b_q <= bmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.app_wr) begin
			cmem[cnt_p1] <= cum_new;
		end
		rd_c_q <= cmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.app_wr) begin
			rmem[count_q[RAW-1:0]] <= rate_q;
		end
		rd_r_q <= rmem[raddr[RAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr_count) begin
			count_q <= '0;
		end else if (cmd.app_wr) begin
			count_q <= cnt_p1;
		end
	end

	always_ff @(posedge clk) begin
		z_q <= (raddr == '0);
		if (cmd.load) begin
			pos_q  <= position;
			rate_q <= rate;
			mass_q <= mass;
			mo_q   <= '0;
			po_q   <= '0;
			idx_q  <= '0;
			st_q   <= ST_OK;
		end
		if (cmd.init_b) begin
			lo_q <= '0;
			hi_q <= count_q;
		end
		if (cmd.init_m) begin
			lo_q <= '0;
			hi_q <= count_q - 1'b1;
		end
		if (cmd.cmp_b) begin
			if (b_eff <= pos_q) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid - 1'b1;
			end
		end
		if (cmd.cmp_m) begin
			if ({1'b0, c_eff} < m_q) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid - 1'b1;
			end
		end
		if (cmd.mul) begin
			prod_q <= MASS_W'((pos_q - b_eff) * r_mul);
		end
		if (cmd.p2m_fin) begin
			mo_q <= (lo_q >= count_q) ? c_eff : cum_new;
		end
		if (cmd.set_m_mass) begin
			m_q <= {1'b0, mass_q};
		end
		if (cmd.set_m_sum) begin
			m_q  <= msum;
			mo_q <= msum[SUM_W-1] ? '1 : msum[MASS_W-1:0];
		end
		if (cmd.idx_lo) begin
			idx_q <= lo_q;
		end
		if (cmd.idx_cnt) begin
			idx_q <= count_q;
		end
		if (cmd.idx_zero) begin
			idx_q <= '0;
		end
		if (cmd.st_we) begin
			st_q <= cmd.st_code;
		end
		if (cmd.po_sat) begin
			po_q <= '1;
			st_q <= ST_SAT;
		end
		if (cmd.div_init) begin
			dq_q   <= m_q - {1'b0, c_eff};
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? rem2 - {1'b0, rd_r_q} : rem2;
			dq_q   <= {dq_q[SUM_W-2:0], ge};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.div_fin) begin
			if (psum[SUM_W:POS_W] != '0) begin
				po_q <= '1;
				st_q <= ST_SAT;
			end else begin
				po_q <= psum[POS_W-1:0];
			end
		end
	end

	assign sts.full     = count_q >= CW'(MAX_INTERVALS);
	assign sts.n_zero   = count_q == '0;
	assign sts.lo_lt_hi = lo_q < hi_q;
	assign sts.m_zero   = m_q == '0;
	assign sts.r_zero   = rd_r_q == '0;
	assign sts.unsorted = pos_q <= b_eff;
	assign sts.div_last = dcnt_q == DCNT_W'(DIV_STEPS - 1);

	assign mass_out       = mo_q;
	assign position_out   = po_q;
	assign interval_index = IDX_W'(idx_q);
	assign status         = st_q;
endmodule
`default_nettype wire

### hdl/rmm_ctrl.sv
// controller state machine sequencing loads, searches and division
`default_nettype none
module rmm_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rmm_pkg::MODE_W-1:0] mode,
	output logic                           busy,
	output logic                           done,
	output rmm_pkg::cmd_t                  cmd,
	input  wire rmm_pkg::sts_t             sts
);
	import rmm_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISP     = 4'd1;
	localparam logic [3:0] S_A_RD     = 4'd2;
	localparam logic [3:0] S_A_CHK    = 4'd3;
	localparam logic [3:0] S_A_WR     = 4'd4;
	localparam logic [3:0] S_A_FIN    = 4'd5;
	localparam logic [3:0] S_SB_PROBE = 4'd6;
	localparam logic [3:0] S_SB_CMP   = 4'd7;
	localparam logic [3:0] S_SB_END   = 4'd8;
	localparam logic [3:0] S_P_ADD    = 4'd9;
	localparam logic [3:0] S_SUM      = 4'd10;
	localparam logic [3:0] S_M_CHK    = 4'd11;
	localparam logic [3:0] S_MB_PROBE = 4'd12;
	localparam logic [3:0] S_MB_CMP   = 4'd13;
	localparam logic [3:0] S_MB_END   = 4'd14;
	localparam logic [3:0] S_DIV      = 4'd15;

	logic [3:0]        state_q, state_d;
	logic [MODE_W-1:0] mode_q;
	logic              done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			mode_q  <= MODE_CLEAR;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == S_IDLE && start && !done_q) begin
				mode_q <= mode;
			end
		end
	end

	// done_q marks the result cycle; the block leaves it back to idle
	assign busy = (state_q != S_IDLE) || done_q;
	assign done = done_q;

	always_comb begin
		cmd     = '0;
		cmd.rsel = RS_LO;
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start && !done_q) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (mode_q)
					MODE_CLEAR: begin
						cmd.clr_count = 1'b1;
						done_d = 1'b1;
						state_d = S_IDLE;
					end
					MODE_APPEND: begin
						if (sts.full) begin
							cmd.st_we   = 1'b1;
							cmd.st_code = ST_FULL;
							cmd.idx_cnt = 1'b1;
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.rsel = RS_CNT;
							state_d  = S_A_RD;
						end
					end
					MODE_INDEX, MODE_P2M, MODE_SHIFT: begin
						if (sts.n_zero) begin
							cmd.st_we   = 1'b1;
							cmd.st_code = ST_EMPTY;
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.init_b = 1'b1;
							state_d = S_SB_PROBE;
						end
					end
					MODE_M2P: begin
						if (sts.n_zero) begin
							cmd.st_we   = 1'b1;
							cmd.st_code = ST_EMPTY;
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.set_m_mass = 1'b1;
							state_d = S_M_CHK;
						end
					end
					default: begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_A_RD: begin
				cmd.rsel = RS_CNT;
				state_d  = S_A_CHK;
			end
			S_A_CHK: begin
				cmd.rsel = RS_CNT;
				if (sts.unsorted) begin
					cmd.st_we   = 1'b1;
					cmd.st_code = ST_UNSORTED;
					cmd.idx_cnt = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.mul     = 1'b1;
					cmd.mul_app = 1'b1;
					state_d = S_A_WR;
				end
			end
			S_A_WR: begin
				cmd.rsel   = RS_CNT;
				cmd.app_wr = 1'b1;
				state_d    = S_A_FIN;
			end
			S_A_FIN: begin
				cmd.idx_cnt = 1'b1;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_SB_PROBE: begin
				if (sts.lo_lt_hi) begin
					cmd.rsel = RS_MID;
					state_d  = S_SB_CMP;
				end else begin
					state_d = S_SB_END;
				end
			end
			S_SB_CMP: begin
				cmd.cmp_b = 1'b1;
				state_d   = S_SB_PROBE;
			end
			S_SB_END: begin
				if (mode_q == MODE_INDEX) begin
					cmd.idx_lo = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_P_ADD;
				end
			end
			S_P_ADD: begin
				cmd.p2m_fin = 1'b1;
				cmd.idx_lo  = 1'b1;
				if (mode_q == MODE_SHIFT) begin
					state_d = S_SUM;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SUM: begin
				cmd.set_m_sum = 1'b1;
				state_d = S_M_CHK;
			end
			S_M_CHK: begin
				if (sts.m_zero) begin
					cmd.idx_zero = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.init_m = 1'b1;
					state_d = S_MB_PROBE;
				end
			end
			S_MB_PROBE: begin
				if (sts.lo_lt_hi) begin
					cmd.rsel = RS_MID;
					state_d  = S_MB_CMP;
				end else begin
					state_d = S_MB_END;
				end
			end
			S_MB_CMP: begin
				cmd.cmp_m = 1'b1;
				state_d   = S_MB_PROBE;
			end
			S_MB_END: begin
				cmd.idx_lo = 1'b1;
				if (sts.r_zero) begin
					cmd.po_sat = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.div_init = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.div_fin = 1'b0;
					state_d = S_IDLE;
					done_d  = 1'b0;
					state_d = S_A_FIN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// division tail: finish into the result registers from the quotient
		if (state_q == S_A_FIN && mode_q != MODE_APPEND) begin
			cmd.idx_cnt = 1'b0;
			cmd.div_fin = 1'b1;
		end
	end
endmodule
`default_nettype wire

### hdl/rmm_checker.sv
// port-level assertions for the piecewise rate mass map, bound to the top level
`default_nettype none
module rmm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [47:0] mass_out,
	input wire logic [31:0] position_out,
	input wire logic [10:0] interval_index,
	input wire logic [2:0]  status
);
	import rmm_pkg::*;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item accepted but not busy");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |->
		(mass_out == '0 && position_out == '0 && interval_index == '0))
		else $error("empty map result not zero");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_SAT) |-> (position_out == '1))
		else $error("saturated position not all ones");
endmodule

bind piecewise_rate_mass_map_top rmm_checker u_rmm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.mass_out       (mass_out),
	.position_out   (position_out),
	.interval_index (interval_index),
	.status         (status)
);
`default_nettype wire
